/* hw/rtl/srsgs_pkg.sv */
// Package for the sparse row store: operation codes, status codes, payload widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package srsgs_pkg;
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    localparam int unsigned CFG_W = 7;
    localparam int unsigned IDX_W = 6;
    localparam int unsigned IN_VAL_W = 32;
    localparam int unsigned CNT_OUT_W = 11;
endpackage
`default_nettype wire

/* hw/rtl/sparse_row_store_get_set.sv */
// Compressed-sparse-row element store, one result word per input word; depends on srsgs_pkg.
// A read or overwrite fetches the row bounds, then binary-searches the columns of the row;
// an insert or delete also shifts the later entries and updates each row end from the row up.
// An out-of-range access skips the search and goes straight to the output state.
// Throughput: one word at a time; s_tready returns once the result register is loaded.
// Reset: synchronous active-low aresetn; S_CLEAR clears every row end, config resets to 64.
`timescale 1ns / 1ps
`default_nettype none
module sparse_row_store_get_set #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLS    = 64,
    parameter int CAPACITY    = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // tdata: operation[0], row_index[6:1], col_index[12:7], write_value[44:13], zero pad
    input  wire logic [47:0] s_tdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: read_value[31:0], found[32], status[34:33], entry_count[45:35], pad
    output logic [47:0]      m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_data
);
    import srsgs_pkg::*;

    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CLW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int VW  = VALUE_WIDTH;

    typedef enum logic [13:0] {
        S_CLEAR  = 14'b00000000000001,
        S_IDLE   = 14'b00000000000010,
        S_RE0    = 14'b00000000000100,
        S_RE1    = 14'b00000000001000,
        S_RE2    = 14'b00000000010000,
        S_SRCH   = 14'b00000000100000,
        S_SRCHW  = 14'b00000001000000,
        S_PROBE  = 14'b00000010000000,
        S_PROBEW = 14'b00000100000000,
        S_DECIDE = 14'b00001000000000,
        S_SHRD   = 14'b00010000000000,
        S_SHWR   = 14'b00100000000000,
        S_ROWS   = 14'b01000000000000,
        S_OUT    = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // memories
    logic [CW-1:0]  row_end_mem [MAX_ROWS];
    logic [CLW-1:0] col_mem [CAPACITY];
    logic [VW-1:0]  val_mem [CAPACITY];

    logic [CW-1:0]  re_rdata;
    logic [CLW-1:0] col_rdata;
    logic [VW-1:0]  val_rdata;

    logic           re_we;
    logic [RW-1:0]  re_waddr, re_raddr;
    logic [CW-1:0]  re_wdata;
    logic           e_we;
    logic [AW-1:0]  e_waddr, e_raddr;
    logic [CLW-1:0] e_wcol;
    logic [VW-1:0]  e_wval;

    always_ff @(posedge aclk) begin
        if (re_we) row_end_mem[re_waddr] <= re_wdata;
        re_rdata <= row_end_mem[re_raddr];
    end

    always_ff @(posedge aclk) begin
        if (e_we) begin
            col_mem[e_waddr] <= e_wcol;
            val_mem[e_waddr] <= e_wval;
        end
        col_rdata <= col_mem[e_raddr];
        val_rdata <= val_mem[e_raddr];
    end

    // registers
    logic [CFG_W-1:0] rows_reg, cols_reg;
    logic             op_reg;
    logic [RW-1:0]    row_reg, row_next;
    logic [CLW-1:0]   col_reg;
    logic [VW-1:0]    wval_reg;
    logic [CW-1:0]    lo_reg, lo_next, hi_reg, hi_next, end_reg, end_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    k_reg, k_next;
    logic             found_reg, found_next;
    logic [1:0]       status_reg, status_next;
    logic [VW-1:0]    rval_reg, rval_next;
    logic             ins_reg, ins_next;
    logic [CLW-1:0]   hcol_reg, hcol_next;
    logic [VW-1:0]    hval_reg, hval_next;
    logic             mvalid_reg;

    // unpack input word
    logic             in_op;
    logic [IDX_W-1:0] in_row, in_col;
    logic [VW-1:0]    in_val;
    assign in_op  = s_tdata[0];
    assign in_row = s_tdata[6:1];
    assign in_col = s_tdata[12:7];
    assign in_val = VW'(signed'(s_tdata[44:13]));

    logic in_range;
    assign in_range = ({1'b0, in_row} < rows_reg) && (32'(in_row) < MAX_ROWS)
                   && ({1'b0, in_col} < cols_reg) && (32'(in_col) < MAX_COLS);

    logic accept;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    logic [CW-1:0] re_clamp, mid;
    assign re_clamp = (32'(re_rdata) > CAPACITY) ? CW'(CAPACITY) : re_rdata;
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb begin
        state_next  = state_reg;
        row_next    = row_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        end_next    = end_reg;
        cnt_next    = cnt_reg;
        k_next      = k_reg;
        found_next  = found_reg;
        status_next = status_reg;
        rval_next   = rval_reg;
        ins_next    = ins_reg;
        hcol_next   = hcol_reg;
        hval_next   = hval_reg;
        re_we    = 1'b0;
        re_waddr = row_reg;
        re_wdata = '0;
        re_raddr = row_reg;
        e_we     = 1'b0;
        e_waddr  = k_reg[AW-1:0];
        e_wcol   = col_reg;
        e_wval   = wval_reg;
        e_raddr  = k_reg[AW-1:0];
        case (state_reg)
            S_CLEAR: begin
                re_we    = 1'b1;
                re_waddr = row_reg;
                if (32'(row_reg) == MAX_ROWS - 1) begin
                    state_next = S_IDLE;
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end
            S_IDLE: begin
                re_raddr = RW'(MAX_ROWS - 1);
                if (accept) begin
                    found_next  = 1'b0;
                    rval_next   = '0;
                    status_next = ST_DONE;
                    row_next    = RW'(in_row);
                    if (!in_range) begin
                        status_next = ST_RANGE;
                        state_next  = S_OUT;
                    end else begin
                        state_next = S_RE0;
                    end
                end
            end
            S_RE0: begin
                // rdata = row_end[last]; request row_end[r-1]
                cnt_next = re_clamp;
                re_raddr = row_reg - 1'b1;
                state_next = S_RE1;
            end
            S_RE1: begin
                lo_next  = (row_reg == '0) ? '0 : re_clamp;
                re_raddr = row_reg;
                state_next = S_RE2;
            end
            S_RE2: begin
                end_next   = re_clamp;
                hi_next    = (re_clamp < lo_reg) ? lo_reg : re_clamp;
                state_next = S_SRCH;
            end
            S_SRCH: begin
                if (lo_reg < hi_reg) begin
                    e_raddr    = mid[AW-1:0];
                    state_next = S_SRCHW;
                end else begin
                    k_next = lo_reg;
                    if (lo_reg < end_reg) begin
                        e_raddr    = lo_reg[AW-1:0];
                        state_next = S_PROBEW;
                    end else begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_SRCHW: begin
                if (col_rdata < col_reg) lo_next = mid + 1'b1;
                else hi_next = mid;
                state_next = S_SRCH;
            end
            S_PROBEW: begin
                found_next = (col_rdata == col_reg);
                if (col_rdata == col_reg && op_reg == OP_READ) rval_next = val_rdata;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                state_next = S_OUT;
                if (op_reg == OP_WRITE) begin
                    if (found_reg) begin
                        if (wval_reg != '0) begin
                            e_we    = 1'b1;
                            e_waddr = lo_reg[AW-1:0];
                        end else begin
                            // delete: move k+1 down to k
                            ins_next = 1'b0;
                            k_next   = lo_reg;
                            state_next = S_SHRD;
                        end
                    end else if (wval_reg != '0) begin
                        if (32'(cnt_reg) >= CAPACITY) begin
                            status_next = ST_FULL;
                        end else begin
                            // insert: carry new entry upward from pos
                            ins_next  = 1'b1;
                            k_next    = lo_reg;
                            hcol_next = col_reg;
                            hval_next = wval_reg;
                            state_next = S_SHRD;
                        end
                    end
                end
            end
            S_SHRD: begin
                // issue read of the entry at k (insert) or k+1 (delete)
                if (ins_reg) begin
                    if (k_reg < cnt_reg) begin
                        e_raddr = k_reg[AW-1:0];
                        state_next = S_SHWR;
                    end else begin
                        e_we    = 1'b1;
                        e_waddr = k_reg[AW-1:0];
                        e_wcol  = hcol_reg;
                        e_wval  = hval_reg;
                        row_next = row_reg;
                        state_next = S_ROWS;
                    end
                end else begin
                    if (k_reg + 1'b1 < cnt_reg) begin
                        e_raddr = AW'(k_reg + 1'b1);
                        state_next = S_SHWR;
                    end else begin
                        state_next = S_ROWS;
                    end
                end
                if (state_next == S_ROWS) re_raddr = row_reg;
            end
            S_SHWR: begin
                e_we    = 1'b1;
                e_waddr = k_reg[AW-1:0];
                if (ins_reg) begin
                    e_wcol    = hcol_reg;
                    e_wval    = hval_reg;
                    hcol_next = col_rdata;
                    hval_next = val_rdata;
                end else begin
                    e_wcol = col_rdata;
                    e_wval = val_rdata;
                end
                k_next = k_reg + 1'b1;
                state_next = S_SHRD;
            end
            S_ROWS: begin
                // rdata = row_end[row]; write adjusted, prefetch next row
                re_we    = 1'b1;
                re_waddr = row_reg;
                if (ins_reg) re_wdata = re_rdata + 1'b1;
                else re_wdata = (re_rdata != '0) ? re_rdata - 1'b1 : re_rdata;
                if (32'(row_reg) == MAX_ROWS - 1) begin
                    cnt_next   = re_wdata;
                    state_next = S_OUT;
                end else begin
                    row_next = row_reg + 1'b1;
                    re_raddr = row_reg + 1'b1;
                end
            end
            S_OUT: begin
                re_raddr = RW'(MAX_ROWS - 1);
                if (!mvalid_reg) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // output register; entry_count comes from the count kept through the access,
    // or straight from the last row end for an out-of-range access
    logic           load_out;
    logic [VW-1:0]  out_val_reg;
    logic           out_found_reg;
    logic [1:0]     out_status_reg;
    logic [CNT_OUT_W-1:0] out_cnt_reg;
    logic           out_pend_reg;
    assign load_out = (state_reg == S_OUT) && !mvalid_reg && out_pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            row_reg      <= '0;
            rows_reg     <= CFG_W'(64);
            cols_reg     <= CFG_W'(64);
            mvalid_reg   <= 1'b0;
            out_pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_ROWS) rows_reg <= cfg_data;
                else if (cfg_index == CFG_COLS) cols_reg <= cfg_data;
            end
            if (accept) out_pend_reg <= 1'b1;
            if (load_out) begin
                out_pend_reg <= 1'b0;
                mvalid_reg   <= 1'b1;
            end else if (mvalid_reg && m_tready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        end_reg    <= end_next;
        cnt_reg    <= cnt_next;
        k_reg      <= k_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        rval_reg   <= rval_next;
        ins_reg    <= ins_next;
        hcol_reg   <= hcol_next;
        hval_reg   <= hval_next;
        if (accept) begin
            op_reg   <= in_op;
            col_reg  <= CLW'(in_col);
            wval_reg <= in_val;
        end
        if (load_out) begin
            out_val_reg    <= rval_reg;
            out_found_reg  <= found_reg;
            out_status_reg <= status_reg;
            out_cnt_reg    <= (status_reg == ST_RANGE) ? CNT_OUT_W'(re_rdata)
                                                       : CNT_OUT_W'(cnt_reg);
        end
    end

    assign m_tvalid = mvalid_reg;
    always_comb begin
        m_tdata        = '0;
        m_tdata[31:0]  = 32'(signed'(out_val_reg));
        m_tdata[32]    = out_found_reg;
        m_tdata[34:33] = out_status_reg;
        m_tdata[45:35] = out_cnt_reg;
    end
endmodule
`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for sparse_row_store_get_set: directed edge cases and
// randomized reads/writes under idle and stall phases. Depends on srsgs_pkg and the RTL.
`timescale 1ns / 1ps
module tb;
    import srsgs_pkg::*;

    typedef struct packed {
        logic [31:0] read_value;
        logic        found;
        logic [1:0]  status;
        logic [10:0] entry_count;
    } access_answer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [47:0] s_tdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_ROWS;
    logic [6:0]  cfg_data = '0;

    sparse_row_store_get_set u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Shadow copy of the store, kept in step with accepted words
    int unsigned shadow_row_end [64];
    logic [5:0]  shadow_col [1024];
    logic [31:0] shadow_val [1024];
    int unsigned rows_limit = 64;
    int unsigned cols_limit = 64;

    access_answer_t pending_answers [$];
    int unsigned    send_idle_pct = 0;
    int unsigned    recv_stall_pct = 0;
    int unsigned    error_count = 0;
    int unsigned    words_sent = 0;
    int unsigned    words_checked = 0;

    // Compute the answer for one access and update the shadow store
    function automatic access_answer_t store_access(logic op, logic [5:0] r, logic [5:0] c,
                                                    logic [31:0] w);
        access_answer_t ans;
        int unsigned lo, hi, mid, cnt, k;
        ans = '0;
        if (r >= rows_limit || c >= cols_limit) begin
            ans.status = ST_RANGE;
        end else begin
            cnt = shadow_row_end[63];
            lo = (r == 0) ? 0 : shadow_row_end[r - 1];
            hi = shadow_row_end[r];
            if (hi < lo) hi = lo;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (shadow_col[mid] < c) lo = mid + 1;
                else hi = mid;
            end
            ans.found = (lo < shadow_row_end[r]) && (shadow_col[lo] == c);
            if (op == OP_READ) begin
                if (ans.found) ans.read_value = shadow_val[lo];
            end else if (ans.found) begin
                if (w != 0) begin
                    shadow_val[lo] = w;
                end else begin
                    // delete: pull later entries down, shrink row ends
                    for (k = lo; k + 1 < cnt; k++) begin
                        shadow_val[k] = shadow_val[k + 1];
                        shadow_col[k] = shadow_col[k + 1];
                    end
                    for (k = r; k < 64; k++)
                        if (shadow_row_end[k] > 0) shadow_row_end[k]--;
                end
            end else if (w != 0) begin
                if (cnt >= 1024) begin
                    ans.status = ST_FULL;
                end else begin
                    // insert: push later entries up, grow row ends
                    for (k = cnt; k > lo; k--) begin
                        shadow_val[k] = shadow_val[k - 1];
                        shadow_col[k] = shadow_col[k - 1];
                    end
                    shadow_val[lo] = w;
                    shadow_col[lo] = c;
                    for (k = r; k < 64; k++) shadow_row_end[k]++;
                end
            end
        end
        ans.entry_count = shadow_row_end[63][10:0];
        return ans;
    endfunction

    // Send one word; hold valid until accepted, then maybe idle a while
    task automatic send_access(logic op, logic [5:0] r, logic [5:0] c, logic [31:0] w);
        s_tdata  <= {3'b000, w, c, r, op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_answers.push_back(store_access(op, r, c, w));
        words_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Drop valid and wait for every answer, then let the block settle
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] value);
        drain();
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_ROWS) rows_limit = value;
        else cols_limit = value;
    endtask

    // Receiver: stall at random per cycle
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Checker: compare each accepted result word with the oldest answer
    always @(posedge aclk) begin
        access_answer_t exp_ans, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[31:0], m_tdata[32], m_tdata[34:33], m_tdata[45:35]};
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, m_tdata);
                error_count++;
            end else begin
                exp_ans = pending_answers.pop_front();
                words_checked++;
                if (got.read_value !== exp_ans.read_value)
                    $display("%0t: read_value exp %h got %h", $time,
                             exp_ans.read_value, got.read_value);
                if (got.found !== exp_ans.found)
                    $display("%0t: found exp %b got %b", $time, exp_ans.found, got.found);
                if (got.status !== exp_ans.status)
                    $display("%0t: status exp %0d got %0d", $time,
                             exp_ans.status, got.status);
                if (got.entry_count !== exp_ans.entry_count)
                    $display("%0t: entry_count exp %0d got %0d", $time,
                             exp_ans.entry_count, got.entry_count);
                if (got !== exp_ans) error_count++;
            end
        end
    end

    // Directed: extremes, ordering inside a row, deletes, range checks
    task automatic test_edges;
        send_access(OP_READ,  6'd0,  6'd0,  32'd0);
        send_access(OP_WRITE, 6'd0,  6'd0,  32'h8000_0000);
        send_access(OP_WRITE, 6'd63, 6'd63, 32'h7FFF_FFFF);
        send_access(OP_WRITE, 6'd0,  6'd40, 32'hFFFF_FFFF);
        send_access(OP_WRITE, 6'd0,  6'd20, 32'h0001_0000);
        send_access(OP_READ,  6'd0,  6'd20, 32'hFFFF_FFFF);
        send_access(OP_READ,  6'd0,  6'd40, 32'd0);
        send_access(OP_READ,  6'd63, 6'd63, 32'd0);
        send_access(OP_WRITE, 6'd0,  6'd20, 32'h0000_0001);
        send_access(OP_WRITE, 6'd5,  6'd7,  32'd0);
        send_access(OP_WRITE, 6'd0,  6'd0,  32'd0);
        send_access(OP_READ,  6'd0,  6'd0,  32'd0);
        send_access(OP_READ,  6'd0,  6'd20, 32'd0);
        write_reg(CFG_COLS, 7'd10);
        send_access(OP_WRITE, 6'd1,  6'd10, 32'h1234_5678);
        send_access(OP_READ,  6'd63, 6'd63, 32'd0);
        send_access(OP_WRITE, 6'd1,  6'd9,  32'h1234_5678);
        write_reg(CFG_ROWS, 7'd1);
        send_access(OP_READ,  6'd1,  6'd9,  32'd0);
        send_access(OP_READ,  6'd0,  6'd0,  32'd0);
        write_reg(CFG_ROWS, 7'd0);
        send_access(OP_READ,  6'd0,  6'd0,  32'd0);
        write_reg(CFG_ROWS, 7'd127);
        write_reg(CFG_COLS, 7'd127);
        send_access(OP_READ,  6'd1,  6'd9,  32'd0);
        send_access(OP_WRITE, 6'd63, 6'd63, 32'd0);
        drain();
    endtask

    // Random accesses over a small window, slightly past the configured limits
    task automatic test_random(int unsigned nrows, int unsigned ncols, int unsigned count,
                               int unsigned idle_pct, int unsigned stall_pct);
        int unsigned i, kind;
        logic [5:0]  r, c;
        logic [31:0] w;
        write_reg(CFG_ROWS, nrows[6:0]);
        write_reg(CFG_COLS, ncols[6:0]);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (i = 0; i < count; i++) begin
            r = 6'($urandom_range((nrows < 63) ? nrows : 63, 0));
            c = 6'($urandom_range((ncols < 63) ? ncols : 63, 0));
            if ($urandom_range(19) == 0) begin
                r = 6'($urandom());
                c = 6'($urandom());
            end
            kind = $urandom_range(99);
            w = (kind < 25) ? 32'd0 : $urandom();
            send_access((kind % 10) < 7 ? OP_WRITE : OP_READ, r, c, w);
        end
        drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_edges();
        test_random(8,  8,  145, 0,  0);
        test_random(64, 64, 145, 49, 0);
        test_random(1,  64, 145, 0,  49);
        test_random(16, 1,  75,  23, 23);
        test_random(6,  12, 75,  23, 23);
        repeat (64) @(posedge aclk);
        $display("Sent %0d access words, checked %0d results across directed, range and idle phases.",
                 words_sent, words_checked);
        if (error_count == 0 && pending_answers.size() == 0) begin
            $display("[sparse_row_store_get_set] OK");
        end else begin
            $display("Failures: %0d, results still missing: %0d", error_count,
                     pending_answers.size());
            $display("[sparse_row_store_get_set] ERROR");
        end
        $finish;
    end

    initial begin
        #400ms;
        $display("Run timed out at %0t", $time);
        $display("[sparse_row_store_get_set] ERROR");
        $finish;
    end
endmodule
